[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the correlation block.
// Depends on nothing; the user supplies the clock and reset names in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

[hdl/pcp_pkg.sv]
// Package for the correlation block: back-end state codes and queue status.
// Depends on nothing.
`timescale 1ns / 1ps
package pcp_pkg;

  // Back-end sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_NORM  = 6'b001000,
    ST_ROOT  = 6'b010000,
    ST_OUT   = 6'b100000
  } back_state_t;

  // Fill status of the window queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int unsigned CAND_W = 16;
  localparam int unsigned MAG_W  = 15;
  localparam int unsigned CORR_W = 16;

endpackage

[hdl/pcp_front.sv]
// Front end: accumulates the window sums and pushes one entry per closed window.
// Depends on pcp_pkg.
`timescale 1ns / 1ps
module pcp_front import pcp_pkg::*; #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int ENTRY_W     = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] x_sample,
  input  logic signed [SAMPLE_BITS-1:0] y_sample,
  input  logic                          last_sample,
  input  logic [CAND_W-1:0]             candidate_index,
  input  logic                          clear_best,
  input  q_status_t                     q_st,
  output logic                          push,
  output logic [ENTRY_W-1:0]            entry
);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SX_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int XY_W  = 2 * SAMPLE_BITS - 1 + CNT_W;

  logic [CNT_W-1:0]              count, count_next;
  logic signed [SX_W-1:0]        sx, sy, sx_next, sy_next;
  logic [SQ_W-1:0]               sxx, syy, sxx_next, syy_next;
  logic signed [XY_W-1:0]        sxy, sxy_next;
  logic signed [2*SAMPLE_BITS-1:0] pxx, pyy, pxy;
  logic                          clr_pend, room, accept;

  // The queue must have room before a beat is taken.
  assign in_stall = q_st.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && last_sample;

  // Products of the current pair.
  assign pxx = x_sample * x_sample;
  assign pyy = y_sample * y_sample;
  assign pxy = x_sample * y_sample;

  // Pairs beyond the window limit are dropped from the sums.
  assign room       = count < CNT_W'(WINDOW_MAX);
  assign count_next = count + CNT_W'(room);
  assign sx_next    = room ? sx + SX_W'(x_sample) : sx;
  assign sy_next    = room ? sy + SX_W'(y_sample) : sy;
  assign sxx_next   = room ? sxx + SQ_W'(pxx) : sxx;
  assign syy_next   = room ? syy + SQ_W'(pyy) : syy;
  assign sxy_next   = room ? sxy + XY_W'(pxy) : sxy;

  // A clear seen anywhere in the window travels with that window's entry.
  assign entry = {clr_pend | clear_best, candidate_index, count_next,
                  sx_next, sy_next, sxx_next, syy_next, sxy_next};

  // Running sums, cleared when a window closes.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sx       <= '0;
      sy       <= '0;
      sxx      <= '0;
      syy      <= '0;
      sxy      <= '0;
      clr_pend <= 1'b0;
    end else if (accept) begin
      if (last_sample) begin
        count    <= '0;
        sx       <= '0;
        sy       <= '0;
        sxx      <= '0;
        syy      <= '0;
        sxy      <= '0;
        clr_pend <= 1'b0;
      end else begin
        count    <= count_next;
        sx       <= sx_next;
        sy       <= sy_next;
        sxx      <= sxx_next;
        syy      <= syy_next;
        sxy      <= sxy_next;
        clr_pend <= clr_pend | clear_best;
      end
    end
  end

endmodule

[hdl/pcp_fifo.sv]
// Two-entry queue of closed windows between the front and the back end.
// Depends on pcp_pkg.
`timescale 1ns / 1ps
module pcp_fifo import pcp_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_status_t        q_st
);
  logic [WIDTH-1:0] mem [2];
  logic             wptr, rptr;
  logic [1:0]       cnt;

  assign q_st.full  = cnt == 2'd2;
  assign q_st.empty = cnt == 2'd0;
  assign rdata      = mem[rptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= '0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

[hdl/pcp_back.sv]
// Back end: forms the coefficient of one window with a shared 64x16 multiplier
// and a bit-serial square-root search, then tracks the peak. Depends on pcp_pkg.
`timescale 1ns / 1ps
module pcp_back import pcp_pkg::*; #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int ENTRY_W     = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ENTRY_W-1:0]       rdata,
  input  q_status_t                q_st,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CORR_W-1:0] corr_value,
  output logic [MAG_W-1:0]         best_magnitude,
  output logic [CAND_W-1:0]        best_candidate,
  output logic                     degenerate
);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SX_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int XY_W  = 2 * SAMPLE_BITS - 1 + CNT_W;

  back_state_t            state;
  logic [ENTRY_W-1:0]     ent;
  logic                   e_clr;
  logic [CAND_W-1:0]      e_cand;
  logic [CNT_W-1:0]       e_n;
  logic signed [SX_W-1:0] e_sx, e_sy;
  logic [SQ_W-1:0]        e_sxx, e_syy;
  logic signed [XY_W-1:0] e_sxy;

  logic [2:0]   prod;
  logic [1:0]   digit;
  logic [63:0]  op_a, op_b;
  logic [15:0]  b_dig;
  logic [79:0]  pp;
  logic [127:0] acc, acc_next;
  logic [63:0]  pa, num, vx, vy, mag;
  logic         neg, degen, big;
  logic [127:0] p_reg, r_reg, s_acc, a_acc, t_s;
  logic [3:0]   k;
  logic [15:0]  q;
  logic         fit, can_out;
  logic [MAG_W-1:0]  pk_mag, pm_new;
  logic [CAND_W-1:0] pk_idx, pi_new;

  assign {e_clr, e_cand, e_n, e_sx, e_sy, e_sxx, e_syy, e_sxy} = ent;
  assign pop     = (state == ST_IDLE) && !q_st.empty;
  assign can_out = !out_valid || !out_stall;

  // Operand selection for the eight products of a window.
  always_comb begin
    case (prod)
      3'd0: begin op_a = 64'(e_n); op_b = 64'(e_sxy); end
      3'd1: begin op_a = 64'(e_sx); op_b = 64'(e_sy); end
      3'd2: begin op_a = 64'(e_n); op_b = 64'(e_sxx); end
      3'd3: begin op_a = 64'(e_sx); op_b = 64'(e_sx); end
      3'd4: begin op_a = 64'(e_n); op_b = 64'(e_syy); end
      3'd5: begin op_a = 64'(e_sy); op_b = 64'(e_sy); end
      3'd6: begin op_a = vx; op_b = vy; end
      default: begin op_a = mag; op_b = mag; end
    endcase
  end

  // One 16-bit digit of the multiplier per cycle.
  assign b_dig    = op_b[{digit, 4'b0000} +: 16];
  assign pp       = op_a * b_dig;
  assign acc_next = acc + ({48'b0, pp} << {digit, 4'b0000});

  // Shift needed while any operand is at or above 2^47.
  assign big = (|mag[63:47]) || (|vx[63:47]) || (|vy[63:47]);

  // Trial of the next root bit: (q + 2^k)^2 * P against R.
  assign t_s = s_acc + (a_acc << (5'(k) + 5'd1)) + (p_reg << {k, 1'b0});
  assign fit = t_s <= r_reg;

  // Peak update for the finished window.
  always_comb begin
    pm_new = e_clr ? '0 : pk_mag;
    pi_new = e_clr ? '0 : pk_idx;
    if (q[MAG_W-1:0] > pm_new) begin
      pm_new = q[MAG_W-1:0];
      pi_new = e_cand;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pk_mag    <= '0;
      pk_idx    <= '0;
    end else begin
      // A taken result beat empties the output register unless a new one loads.
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            ent   <= rdata;
            prod  <= 3'd0;
            digit <= 2'd0;
            acc   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          digit <= digit + 2'd1;
          if (digit == 2'd3) begin
            acc  <= '0;
            prod <= prod + 3'd1;
            case (prod) inside
              3'd0, 3'd2, 3'd4: pa <= acc_next[63:0];
              3'd1: num <= pa - acc_next[63:0];
              3'd3: vx <= pa - acc_next[63:0];
              3'd5: begin
                vy    <= pa - acc_next[63:0];
                state <= ST_CHECK;
              end
              3'd6: p_reg <= acc_next;
              default: begin
                r_reg <= acc_next << 30;
                s_acc <= '0;
                a_acc <= '0;
                q     <= '0;
                k     <= 4'd15;
                state <= ST_ROOT;
              end
            endcase
          end else begin
            acc <= acc_next;
          end
        end
        ST_CHECK: begin
          neg   <= num[63];
          mag   <= num[63] ? 64'd0 - num : num;
          degen <= (vx == 64'd0) || vx[63] || (vy == 64'd0) || vy[63];
          if ((vx == 64'd0) || vx[63] || (vy == 64'd0) || vy[63]) begin
            q     <= '0;
            state <= ST_OUT;
          end else begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (big) begin
            mag <= mag >> 1;
            vx  <= vx >> 1;
            vy  <= vy >> 1;
          end else begin
            prod  <= 3'd6;
            digit <= 2'd0;
            acc   <= '0;
            state <= ST_MUL;
          end
        end
        ST_ROOT: begin
          // A full-scale root saturates at once.
          if (fit && k == 4'd15) begin
            q     <= 16'h7FFF;
            state <= ST_OUT;
          end else begin
            if (fit) begin
              s_acc <= t_s;
              a_acc <= a_acc + (p_reg << k);
              q[k]  <= 1'b1;
            end
            k <= k - 4'd1;
            if (k == 4'd0) begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (can_out) begin
            out_valid      <= 1'b1;
            corr_value     <= neg ? 16'd0 - q : q;
            best_magnitude <= pm_new;
            best_candidate <= pi_new;
            degenerate     <= degen;
            pk_mag         <= pm_new;
            pk_idx         <= pi_new;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[hdl/pearson_correlation_peak_top.sv]
// Windowed Pearson correlation with peak tracking.
// The input channel takes one beat per sample pair (in_valid, in_stall); a beat
// with last_sample high closes the window. The output channel (out_valid,
// out_stall) carries one beat per closed window: the Q1.15 coefficient, the
// peak magnitude and candidate since the last clear, and a degenerate flag.
// The front end takes one pair per cycle while in_stall is low. The back end
// takes one window at a time, popping the next only when idle: a pop, six
// products on the shared 64x16 multiplier, a check, and, unless the window is
// degenerate, the normalising shifts (none at the default widths, up to 17 for
// wider ones), two more products and 1 to 16 root steps; then an output load.
// A two-entry queue holds closed windows, so in_stall rises only when two
// windows wait for the back end.
// A stalled result holds in the output register and the back end waits on it.
// Reset clears the sums, the queue, the peak and out_valid; nothing else needs
// a clearing pass.
// Depends on pcp_pkg, pcp_front, pcp_fifo, pcp_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pearson_correlation_peak_top import pcp_pkg::*; #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] x_sample,
  input  logic signed [SAMPLE_BITS-1:0] y_sample,
  input  logic                          last_sample,
  input  logic [CAND_W-1:0]             candidate_index,
  input  logic                          clear_best,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [CORR_W-1:0]      corr_value,
  output logic [MAG_W-1:0]              best_magnitude,
  output logic [CAND_W-1:0]             best_candidate,
  output logic                          degenerate
);
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int ENTRY_W = 1 + CAND_W + CNT_W + 2 * (SAMPLE_BITS + CNT_W)
                         + 2 * (2 * SAMPLE_BITS - 2 + CNT_W)
                         + (2 * SAMPLE_BITS - 1 + CNT_W);

  logic               push, pop;
  logic [ENTRY_W-1:0] wdata, rdata;
  q_status_t          q_st;
  logic [CORR_W-1:0]  corr_abs;

  // Accumulation of the open window.
  pcp_front #(
    .WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS), .ENTRY_W(ENTRY_W)
  ) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .x_sample(x_sample), .y_sample(y_sample), .last_sample(last_sample),
    .candidate_index(candidate_index), .clear_best(clear_best),
    .q_st(q_st), .push(push), .entry(wdata)
  );

  // Queue of closed windows.
  pcp_fifo #(.WIDTH(ENTRY_W)) u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(wdata), .pop(pop),
    .rdata(rdata), .q_st(q_st)
  );

  // Coefficient and peak.
  pcp_back #(
    .WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS), .ENTRY_W(ENTRY_W)
  ) u_back (
    .clk(clk), .rst(rst), .rdata(rdata), .q_st(q_st), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .corr_value(corr_value),
    .best_magnitude(best_magnitude), .best_candidate(best_candidate),
    .degenerate(degenerate)
  );

  assign corr_abs = corr_value[CORR_W-1] ? CORR_W'(0) - corr_value : corr_value;

  // No queue overflow; a degenerate window reports zero; |corr| <= peak.
  `ASSERT_IMPLY(a_no_overflow, clk, rst, push, !q_st.full)
  `ASSERT_IMPLY(a_degen_zero, clk, rst, out_valid && degenerate, corr_value == '0)
  `ASSERT_IMPLY(a_peak_bound, clk, rst, out_valid, corr_abs <= CORR_W'(best_magnitude))

endmodule
